// ----- src/she_pkg.sv -----
// she_pkg: shared widths, request and result codes, and structs for the
// spectrum histogram engine. No dependencies; every other file imports it.
package she_pkg;

    localparam int REQ_W   = 2;
    localparam int CH_W    = 16;
    localparam int INC_W   = 16;
    localparam int NC_W    = 13;
    localparam int CNT_W   = 17;   // channel index or count up to 65536
    localparam int TOTAL_W = 44;
    localparam int PEAK_W  = 12;
    localparam int KIND_W  = 2;

    localparam logic [REQ_W-1:0] REQ_INC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SUM = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MAX = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLR = 2'd3;

    localparam logic [KIND_W-1:0] DK_SUM = 2'd0;
    localparam logic [KIND_W-1:0] DK_MAX = 2'd1;
    localparam logic [KIND_W-1:0] DK_CLR = 2'd2;

    localparam logic [NC_W-1:0]    NUM_CH_RESET = 13'd4096;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [TOTAL_W-1:0] range_total;
        logic [PEAK_W-1:0]  peak_channel;
        logic               range_error;
        logic [KIND_W-1:0]  done_kind;
    } she_res_t;

    // Range request handed to the sequencer, with the channel count in force.
    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic [CH_W-1:0]  first;
        logic [CH_W-1:0]  last;
        logic [CNT_W-1:0] count;
    } she_cmd_t;

    // One bin access from the sequencer: read, or write of zero.
    typedef struct packed {
        logic             rd;
        logic             wr;
        logic [CNT_W-1:0] ch;
    } she_mem_req_t;

endpackage

// ----- src/she_if.sv -----
// she_if: valid/ready channel interfaces for requests, results and the
// channel-count register. Depends on she_pkg for field widths.
interface she_req_if;
    import she_pkg::*;
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [CH_W-1:0]    first_channel;
    logic [CH_W-1:0]    last_channel;
    logic [INC_W-1:0]   increment;

    modport source (output valid, req_type, first_channel, last_channel, increment,
                    input ready);
    modport sink   (input valid, req_type, first_channel, last_channel, increment,
                    output ready);
endinterface

interface she_res_if;
    import she_pkg::*;
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] range_total;
    logic [PEAK_W-1:0]  peak_channel;
    logic               range_error;
    logic [KIND_W-1:0]  done_kind;

    modport source (output valid, range_total, peak_channel, range_error, done_kind,
                    input ready);
    modport sink   (input valid, range_total, peak_channel, range_error, done_kind,
                    output ready);
endinterface

interface she_cfg_if;
    import she_pkg::*;
    logic               valid;
    logic               ready;
    logic [NC_W-1:0]    num_channels;

    modport source (output valid, num_channels, input ready);
    modport sink   (input valid, num_channels, output ready);
endinterface

// ----- src/she_range_seq.sv -----
// she_range_seq: walks a channel range over the bin memory for integrate,
// max and clear requests, one bin per cycle. Depends on she_pkg.
module she_range_seq #(
    parameter int COUNT_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  she_pkg::she_cmd_t        cmd,
    output logic                     busy,
    output she_pkg::she_mem_req_t    mem_req,
    input  logic [COUNT_BITS-1:0]    rd_data,
    output logic                     res_valid,
    input  logic                     res_free,
    output she_pkg::she_res_t        res
);
    import she_pkg::*;

    localparam int SW = ((COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W) + 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SETUP  = 2'd1;
    localparam logic [1:0] S_RUN    = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]            state_reg, state_next;
    she_cmd_t              cmd_reg;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic [CNT_W-1:0]      end_reg, end_next;
    logic                  err_reg, err_next;
    logic                  rd_valid_reg;
    logic [PEAK_W-1:0]     rd_ch_reg;
    logic [TOTAL_W-1:0]    sum_reg;
    logic [COUNT_BITS-1:0] best_reg;
    logic [PEAK_W-1:0]     peak_reg;

    logic [CH_W-1:0]       lo, hi;
    logic [CNT_W-1:0]      start_ch, bound, last_p1;
    logic                  access;
    logic [SW-1:0]         sum_ext;
    logic [TOTAL_W-1:0]    sum_sat;

    // Range bounds, all as half-open [start_ch, bound).
    always_comb
    begin
        lo      = (cmd_reg.first > cmd_reg.last) ? cmd_reg.last : cmd_reg.first;
        hi      = (cmd_reg.first > cmd_reg.last) ? cmd_reg.first : cmd_reg.last;
        last_p1 = CNT_W'(cmd_reg.last) + CNT_W'(1);
        start_ch = CNT_W'(cmd_reg.first);
        bound    = CNT_W'(0);
        err_next = err_reg;
        case (cmd_reg.kind)
            REQ_SUM:
            begin
                start_ch = CNT_W'(lo);
                bound    = (CNT_W'(hi) >= cmd_reg.count) ? CNT_W'(lo) : CNT_W'(hi);
            end
            REQ_MAX:
            begin
                bound = (CNT_W'(cmd_reg.last) < cmd_reg.count) ? CNT_W'(cmd_reg.last)
                                                               : cmd_reg.count;
            end
            REQ_CLR:
            begin
                bound = (last_p1 < cmd_reg.count) ? last_p1 : cmd_reg.count;
            end
            default:
            begin
                bound = start_ch;
            end
        endcase
        if (state_reg == S_SETUP)
        begin
            err_next = (cmd_reg.kind == REQ_SUM) && (CNT_W'(hi) >= cmd_reg.count);
        end
    end

    assign access = (state_reg == S_RUN) && (ptr_reg < end_reg);

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                ptr_next   = start_ch;
                end_next   = (bound > start_ch) ? bound : start_ch;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (access)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mem_req.rd = access && (cmd_reg.kind != REQ_CLR);
    assign mem_req.wr = access && (cmd_reg.kind == REQ_CLR);
    assign mem_req.ch = ptr_reg;

    assign sum_ext = SW'(sum_reg) + SW'(rd_data);
    assign sum_sat = (sum_ext > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= mem_req.rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
        end
        ptr_reg   <= ptr_next;
        end_reg   <= end_next;
        err_reg   <= err_next;
        rd_ch_reg <= ptr_reg[PEAK_W-1:0];
        if (state_reg == S_SETUP)
        begin
            sum_reg  <= '0;
            best_reg <= '0;
            peak_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            sum_reg <= sum_sat;
            // Strictly greater keeps the first channel of the highest count.
            if (rd_data > best_reg)
            begin
                best_reg <= rd_data;
                peak_reg <= rd_ch_reg;
            end
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_FINISH);

    always_comb
    begin
        res = '0;
        case (cmd_reg.kind)
            REQ_SUM:
            begin
                res.done_kind   = DK_SUM;
                res.range_error = err_reg;
                res.range_total = err_reg ? '0 : sum_reg;
            end
            REQ_MAX:
            begin
                res.done_kind    = DK_MAX;
                res.peak_channel = peak_reg;
            end
            default:
            begin
                res.done_kind = DK_CLR;
            end
        endcase
    end

    a_ptr_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (ptr_reg <= end_reg))
        else $error("range pointer ran past its end");

    a_err_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && cmd_reg.kind == REQ_SUM && err_reg) |-> (sum_reg == '0))
        else $error("bins summed on an out-of-range integrate");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg) |-> (cmd_reg.kind == REQ_SUM || cmd_reg.kind == REQ_MAX))
        else $error("read data returned for a clear walk");

endmodule

// ----- src/spectrum_histogram_engine_core.sv -----
// spectrum_histogram_engine_core: top level of the pulse-height histogram,
// holding the bin memory, increment pipeline and result register.
// Depends on she_pkg, she_if and she_range_seq.
//
//  channel | dir | transfer carries
//  --------+-----+---------------------------------------------------------
//  req     | in  | req_type, first_channel, last_channel, increment
//  res     | out | range_total, peak_channel, range_error, done_kind
//  cfg     | in  | num_channels (effective count = min(num_channels, MAX_CHANNELS))
//
//  Increments: one per cycle, read-modify-write over the single memory with a
//    one-entry forward of the previous cycle's write.
//  Integrate / max / clear: the range sequencer walks the range,
//    one bin per cycle on the memory port; no request transfers meanwhile.
//  Reset: a clearing pass writes zero to every bin with req.ready low; cfg
//    writes are taken throughout.
//  Stalls: a finished result waits in the output register, and increments keep
//    flowing behind it; a second range result waits in the sequencer.
module spectrum_histogram_engine_core #(
    parameter int MAX_CHANNELS = 4096,
    parameter int COUNT_BITS   = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    she_req_if.sink      req,
    she_res_if.source    res,
    she_cfg_if.sink      cfg
);
    import she_pkg::*;

    localparam int AW = $clog2(MAX_CHANNELS);
    localparam int IW = ((COUNT_BITS > INC_W) ? COUNT_BITS : INC_W) + 1;
    localparam logic [IW-1:0] BIN_MAX = {{(IW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    logic [COUNT_BITS-1:0] bin_mem [MAX_CHANNELS];

    logic [NC_W-1:0]       num_channels_reg;
    logic [CNT_W-1:0]      count_eff;

    logic                  init_busy_reg;
    logic [AW-1:0]         init_ptr_reg;

    logic                  s1_valid_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic [INC_W-1:0]      s1_inc_reg;
    logic                  fwd_valid_reg;
    logic [AW-1:0]         fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic [COUNT_BITS-1:0] base;
    logic [IW-1:0]         inc_sum;
    logic [COUNT_BITS-1:0] inc_new;

    logic                  req_xfer, inc_xfer, inc_hit, seq_start;
    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    logic                  seq_busy, seq_res_valid;
    she_cmd_t              seq_cmd;
    she_mem_req_t          seq_mem;
    she_res_t              seq_res;

    logic                  out_valid_reg, out_valid_next;
    she_res_t              out_res_reg;
    logic                  out_free, out_load;

    // Channel count in force, clamped to the memory depth.
    assign count_eff = (CNT_W'(num_channels_reg) > CNT_W'(MAX_CHANNELS))
                       ? CNT_W'(MAX_CHANNELS) : CNT_W'(num_channels_reg);

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg <= NUM_CH_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            num_channels_reg <= cfg.num_channels;
        end
    end

    // Hold requests off while the clearing pass or a range walk owns the memory.
    assign req.ready = !init_busy_reg && !seq_busy;
    assign req_xfer  = req.valid && req.ready;
    assign inc_xfer  = req_xfer && (req.req_type == REQ_INC);
    // Drop increments to channels at or beyond the count.
    assign inc_hit   = inc_xfer && (CNT_W'(req.first_channel) < count_eff);
    assign seq_start = req_xfer && (req.req_type != REQ_INC);

    assign seq_cmd.kind  = req.req_type;
    assign seq_cmd.first = req.first_channel;
    assign seq_cmd.last  = req.last_channel;
    assign seq_cmd.count = count_eff;

    she_range_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (seq_start),
        .cmd       (seq_cmd),
        .busy      (seq_busy),
        .mem_req   (seq_mem),
        .rd_data   (rd_data_reg),
        .res_valid (seq_res_valid),
        .res_free  (out_free),
        .res       (seq_res)
    );

    // Clearing pass after reset: one bin per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b1;
            init_ptr_reg  <= '0;
        end
        else if (init_busy_reg)
        begin
            init_ptr_reg <= init_ptr_reg + AW'(1);
            if (init_ptr_reg == AW'(MAX_CHANNELS - 1))
            begin
                init_busy_reg <= 1'b0;
            end
        end
    end

    // Increment stage: the read issued at transfer returns here. The write of
    // the cycle before is not yet visible in that read, so forward it.
    assign base    = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg
                                                                    : rd_data_reg;
    assign inc_sum = IW'(base) + IW'(s1_inc_reg);
    assign inc_new = (inc_sum > BIN_MAX) ? {COUNT_BITS{1'b1}} : inc_sum[COUNT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= inc_hit;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= req.first_channel[AW-1:0];
        s1_inc_reg   <= req.increment;
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= inc_new;
    end

    // Memory port selection: clearing pass, then increment write-back, then
    // the sequencer. The sequencer is never busy while an increment is in flight.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = seq_mem.ch[AW-1:0];
        wr_data = '0;
        if (init_busy_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = init_ptr_reg;
        end
        else if (s1_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = s1_addr_reg;
            wr_data = inc_new;
        end
        else if (seq_mem.wr)
        begin
            wr_en = 1'b1;
        end
    end

    assign rd_en   = inc_hit || seq_mem.rd;
    assign rd_addr = inc_hit ? req.first_channel[AW-1:0] : seq_mem.ch[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= bin_mem[rd_addr];
        end
    end

    // Output register: load a finished range result when the slot is free.
    assign out_free = !out_valid_reg || res.ready;
    assign out_load = seq_res_valid && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg <= seq_res;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.range_total  = out_res_reg.range_total;
    assign res.peak_channel = out_res_reg.peak_channel;
    assign res.range_error  = out_res_reg.range_error;
    assign res.done_kind    = out_res_reg.done_kind;

    a_wr_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && seq_mem.wr))
        else $error("increment write-back collided with a clear write");

    a_seq_after_inc: assert property (@(posedge clk) disable iff (!rst_n)
        seq_busy |-> !s1_valid_reg)
        else $error("range walk overlapped an increment in flight");

    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy_reg |-> (!s1_valid_reg && !seq_busy && !out_valid_reg))
        else $error("activity during the clearing pass");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> (out_res_reg == $past(out_res_reg)))
        else $error("pending result overwritten");

endmodule
